### sv/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants for the linear-fit R squared block: result
// widths, the arithmetic word sizes, the controller states, the product
// schedule and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lfr_pkg;

    // Default configuration
    localparam int DEF_MAX_SAMPLES  = 4096;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Result fields
    localparam int R_W         = 16;
    localparam int COUNT_OUT_W = 13;
    localparam logic [R_W-1:0] R_ONE = 16'h8000;   // 1.0 in Q1.15

    // Final arithmetic: 64-bit moments, 128-bit products
    localparam int CALC_W    = 64;
    localparam int PROD_W    = 2 * CALC_W;
    localparam int MUL_STEPS = CALC_W;   // one multiplier bit per cycle
    localparam int DIV_STEPS = 15;       // one quotient bit per cycle
    localparam int STEP_W    = $clog2(MUL_STEPS);

    // Controller states
    typedef enum logic [2:0] {
        ST_ACC,
        ST_DRAIN,
        ST_MUL_LOAD,
        ST_MUL_STEP,
        ST_MUL_STORE,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_FINISH
    } lfr_state_t;

    // Product schedule, in the order the controller walks it
    typedef enum logic [2:0] {
        P_N_SXY,
        P_SX_SY,
        P_N_SXX,
        P_SX_SX,
        P_N_SYY,
        P_SY_SY,
        P_COV_SQ,
        P_VAR_PROD
    } prod_sel_t;

    typedef struct packed {
        logic      accept;
        logic      mul_load;
        logic      mul_step;
        logic      mul_store;
        prod_sel_t sel;
        logic      div_init;
        logic      div_step;
        logic      finish;
    } lfr_cmd_t;

    typedef struct packed {
        logic res_busy;
    } lfr_status_t;

endpackage

### sv/lfr_sample_if.sv
// ----------------------------------------------------------------------------
// lfr_sample_if
// Sample channel: one (x, y) pair per beat, with a marker on the final pair.
// ----------------------------------------------------------------------------
interface lfr_sample_if
    import lfr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] x_value;
    logic signed [SAMPLE_WIDTH-1:0] y_value;
    logic                           last_sample;

    modport source (output valid, output x_value, output y_value,
                    output last_sample, input ready);
    modport sink   (input valid, input x_value, input y_value,
                    input last_sample, output ready);
endinterface

### sv/lfr_result_if.sv
// ----------------------------------------------------------------------------
// lfr_result_if
// Result channel: one beat per data set, carrying R squared and its flags.
// ----------------------------------------------------------------------------
interface lfr_result_if
    import lfr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [R_W-1:0]         r_squared;
    logic                   degenerate;
    logic                   overflow;
    logic [COUNT_OUT_W-1:0] sample_count;

    modport source (output valid, output r_squared, output degenerate,
                    output overflow, output sample_count, input ready);
    modport sink   (input valid, input r_squared, input degenerate,
                    input overflow, input sample_count, output ready);
endinterface

### sv/lfr_controller.sv
// ----------------------------------------------------------------------------
// lfr_controller
// Sequencer: takes samples while accumulating, then walks the eight-product
// schedule on the shared shift-add multiplier, runs the quotient steps and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module lfr_controller
    import lfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  lfr_status_t status,
    output lfr_cmd_t    cmd
);

    lfr_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    prod_sel_t         idx_reg,   idx_next;

    // State, step counter and product index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            step_reg  <= '0;
            idx_reg   <= P_N_SXY;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_ACC:
            begin
                if (in_valid && in_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // last pair lands in the sums this cycle
                idx_next   = P_N_SXY;
                state_next = ST_MUL_LOAD;
            end
            ST_MUL_LOAD:
            begin
                step_next  = '0;
                state_next = ST_MUL_STEP;
            end
            ST_MUL_STEP:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                    state_next = ST_MUL_STORE;
            end
            ST_MUL_STORE:
            begin
                if (idx_reg == P_VAR_PROD)
                    state_next = ST_DIV_INIT;
                else
                begin
                    idx_next   = prod_sel_t'(idx_reg + 1'b1);
                    state_next = ST_MUL_LOAD;
                end
            end
            ST_DIV_INIT:
            begin
                step_next  = '0;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.res_busy)
                    state_next = ST_ACC;
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.sel       = idx_reg;
        unique case (state_reg)
            ST_ACC:       in_ready      = 1'b1;
            ST_DRAIN:     ;
            ST_MUL_LOAD:  cmd.mul_load  = 1'b1;
            ST_MUL_STEP:  cmd.mul_step  = 1'b1;
            ST_MUL_STORE: cmd.mul_store = 1'b1;
            ST_DIV_INIT:  cmd.div_init  = 1'b1;
            ST_DIV_STEP:  cmd.div_step  = 1'b1;
            ST_FINISH:    cmd.finish    = !status.res_busy;
            default:      ;
        endcase
        cmd.accept = in_valid && in_ready;
    end

endmodule

### sv/lfr_datapath.sv
// ----------------------------------------------------------------------------
// lfr_datapath
// Moment accumulators, a one-bit-per-cycle 64x64 shift-add multiplier, a
// restoring quotient unit and the result register.
// ----------------------------------------------------------------------------
module lfr_datapath
    import lfr_pkg::*;
#(
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lfr_cmd_t                       cmd,
    output lfr_status_t                    status,
    input  logic signed [SAMPLE_WIDTH-1:0] x_value,
    input  logic signed [SAMPLE_WIDTH-1:0] y_value,
    input  logic                           res_ready,
    output logic                           res_valid,
    output logic [R_W-1:0]                 r_squared,
    output logic                           degenerate,
    output logic                           overflow,
    output logic [COUNT_OUT_W-1:0]         sample_count
);

    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_RAW_W = SAMPLE_WIDTH + CNT_W;
    localparam int SUM_W     = (SUM_RAW_W > CALC_W) ? CALC_W : SUM_RAW_W;
    localparam int SQ_RAW_W  = 2 * SAMPLE_WIDTH + CNT_W;
    localparam int SQ_W      = (SQ_RAW_W > CALC_W) ? CALC_W : SQ_RAW_W;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SAMPLES);

    // Sample stage
    logic signed [SAMPLE_WIDTH-1:0]   x_stg_reg, y_stg_reg;
    logic                             stg_en_reg;
    logic signed [2*SAMPLE_WIDTH-1:0] xx_prod, yy_prod, xy_prod;

    // Moments
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic signed [SQ_W-1:0]  sxx_reg, syy_reg, sxy_reg;
    logic                    room;

    // Final arithmetic
    logic [CALC_W-1:0] n_ext, sx_ext, sy_ext, sxx_ext, syy_ext, sxy_ext;
    logic [CALC_W-1:0] t_reg, cov_reg, vx_reg, vy_reg, cov_abs;
    logic [CALC_W-1:0] op_a, op_b, prod_low;
    logic [PROD_W-1:0] ma_reg, prod_reg, den_reg;
    logic [CALC_W-1:0] mb_reg;
    logic [PROD_W:0]   rem_reg, rem_shift, den_ext, rem_sub;
    logic              rem_ge;
    logic [R_W-1:0]    quo_reg;
    logic              sat_reg;
    logic              degen;

    // Result register
    logic                   res_valid_reg;
    logic [R_W-1:0]         r_reg;
    logic                   degen_reg, ovf_out_reg;
    logic [COUNT_OUT_W-1:0] count_reg;

    assign room = (cnt_reg < CNT_LIMIT);

    // Capture the accepted pair
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_stg_reg <= x_value;
            y_stg_reg <= y_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_en_reg <= 1'b0;
        else
            stg_en_reg <= cmd.accept && room;
    end

    assign xx_prod = x_stg_reg * x_stg_reg;
    assign yy_prod = y_stg_reg * y_stg_reg;
    assign xy_prod = x_stg_reg * y_stg_reg;

    // Count, overflow and moment accumulation; cleared when the result register is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end
        else if (cmd.finish)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (room)
                    cnt_reg <= cnt_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (stg_en_reg)
            begin
                sx_reg  <= sx_reg  + SUM_W'(x_stg_reg);
                sy_reg  <= sy_reg  + SUM_W'(y_stg_reg);
                sxx_reg <= sxx_reg + SQ_W'(xx_prod);
                syy_reg <= syy_reg + SQ_W'(yy_prod);
                sxy_reg <= sxy_reg + SQ_W'(xy_prod);
            end
        end
    end

    // Moments as 64-bit two's complement
    assign n_ext   = CALC_W'(cnt_reg);
    assign sx_ext  = CALC_W'(sx_reg);
    assign sy_ext  = CALC_W'(sy_reg);
    assign sxx_ext = CALC_W'(sxx_reg);
    assign syy_ext = CALC_W'(syy_reg);
    assign sxy_ext = CALC_W'(sxy_reg);
    assign cov_abs = cov_reg[CALC_W-1] ? (CALC_W'(0) - cov_reg) : cov_reg;

    // Multiplier operand select
    always_comb
    begin
        unique case (cmd.sel)
            P_N_SXY:    begin op_a = n_ext;   op_b = sxy_ext; end
            P_SX_SY:    begin op_a = sx_ext;  op_b = sy_ext;  end
            P_N_SXX:    begin op_a = n_ext;   op_b = sxx_ext; end
            P_SX_SX:    begin op_a = sx_ext;  op_b = sx_ext;  end
            P_N_SYY:    begin op_a = n_ext;   op_b = syy_ext; end
            P_SY_SY:    begin op_a = sy_ext;  op_b = sy_ext;  end
            P_COV_SQ:   begin op_a = cov_abs; op_b = cov_abs; end
            P_VAR_PROD: begin op_a = vx_reg;  op_b = vy_reg;  end
            default:    begin op_a = '0;      op_b = '0;      end
        endcase
    end

    assign prod_low = prod_reg[CALC_W-1:0];

    // Quotient step: shift in a zero, subtract the divisor when it fits
    assign rem_shift = {rem_reg[PROD_W-1:0], 1'b0};
    assign den_ext   = {1'b0, den_reg};
    assign rem_ge    = (rem_shift >= den_ext);
    assign rem_sub   = rem_shift - den_ext;

    // Shift-add multiplier, term combination and divider
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            ma_reg   <= PROD_W'(op_a);
            mb_reg   <= op_b;
            prod_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mb_reg[0])
                prod_reg <= prod_reg + ma_reg;
            ma_reg <= {ma_reg[PROD_W-2:0], 1'b0};
            mb_reg <= {1'b0, mb_reg[CALC_W-1:1]};
        end

        if (cmd.mul_store)
        begin
            unique case (cmd.sel) inside
                P_N_SXY, P_N_SXX, P_N_SYY: t_reg   <= prod_low;
                P_SX_SY:                   cov_reg <= t_reg - prod_low;
                P_SX_SX:                   vx_reg  <= t_reg - prod_low;
                P_SY_SY:                   vy_reg  <= t_reg - prod_low;
                P_COV_SQ:                  rem_reg <= {1'b0, prod_reg};
                P_VAR_PROD:                den_reg <= prod_reg;
                default:                   ;
            endcase
        end
        else if (cmd.div_init)
        begin
            sat_reg <= (rem_reg[PROD_W-1:0] >= den_reg);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub : rem_shift;
            quo_reg <= {quo_reg[R_W-2:0], rem_ge};
        end
    end

    assign degen = (vx_reg == '0) || (vy_reg == '0);

    // Result register: loaded on finish, freed when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.finish)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            r_reg       <= degen ? '0 : (sat_reg ? R_ONE : quo_reg);
            degen_reg   <= degen;
            ovf_out_reg <= ovf_reg;
            count_reg   <= n_ext[COUNT_OUT_W-1:0];
        end
    end

    assign status.res_busy = res_valid_reg && !res_ready;
    assign res_valid       = res_valid_reg;
    assign r_squared       = r_reg;
    assign degenerate      = degen_reg;
    assign overflow        = ovf_out_reg;
    assign sample_count    = count_reg;

endmodule

### sv/linear_fit_r_squared.sv
// ----------------------------------------------------------------------------
// linear_fit_r_squared
// Coefficient of determination of the least-squares line through a stream of
// (x, y) sample pairs.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while a data set is being accumulated; the
// products for each pair are added into the moment sums in the following
// cycle. When the pair marked last is taken, the sample port goes not-ready
// while R squared is formed: a drain step for the last pair to land, eight
// 64x64 products on a shared shift-add multiplier (each a load, 64 bit steps
// and a store), a set-up step, fifteen restoring quotient steps and a finish
// step that loads the result register. The result beat waits in that
// register while the next data set is already being taken; a second last
// pair holds the block in its finish step until the earlier result has gone.
// Pairs beyond MAX_SAMPLES are dropped and flagged; a zero x or y variance
// gives 0 with the degenerate flag set.
// ----------------------------------------------------------------------------
module linear_fit_r_squared
    import lfr_pkg::*;
#(
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input logic         clk,
    input logic         rst_n,
    lfr_sample_if.sink  sample,
    lfr_result_if.source result
);

    lfr_cmd_t    cmd;
    lfr_status_t status;
    logic        in_ready;

    lfr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_last  (sample.last_sample),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lfr_datapath #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .x_value      (sample.x_value),
        .y_value      (sample.y_value),
        .res_ready    (result.ready),
        .res_valid    (result.valid),
        .r_squared    (result.r_squared),
        .degenerate   (result.degenerate),
        .overflow     (result.overflow),
        .sample_count (result.sample_count)
    );

    assign sample.ready = in_ready;

    // A last pair closes the data set: no beat is taken in the next cycle
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready && sample.last_sample |=> !sample.ready)
        else $error("sample taken straight after a last pair");

    // R squared never exceeds 1.0
    a_r_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.r_squared <= R_ONE)
        else $error("r_squared above 1.0");

    // Degenerate data sets report zero
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.degenerate |-> result.r_squared == '0)
        else $error("degenerate result with nonzero r_squared");

endmodule
